[rtl/core/btlv_pkg.sv]
// Shared types and codes for the BER TLV stream decoder.
// Depends on nothing; other rtl/core files but btlv_fifo use it by scoped names.

package btlv_pkg;

	// Event kinds reported for each byte.
	localparam logic [1:0] KIND_TAG   = 2'd0;
	localparam logic [1:0] KIND_LEN   = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	// Error codes reported on the byte that closes a TLV.
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_TAG_SHORT = 2'd1;
	localparam logic [1:0] ERR_LEN_SHORT = 2'd2;
	localparam logic [1:0] ERR_VAL_SHORT = 2'd3;

	// Byte patterns used by the classifier.
	localparam logic [4:0] TAG_EXT_MASK = 5'h1F;

	// A classified input byte, as held in the queue between front and back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bit7;      // continuation or long-form flag
		logic       tag_ext;   // low five bits all ones
		logic       cnt_zero;  // low seven bits all zero
	} byte_item_t;

	// One decoded result, as held in the result queue.
	typedef struct packed {
		logic [1:0]  event_kind;
		logic [31:0] tag_value;
		logic [31:0] length_value;
		logic [7:0]  value_byte;
		logic        header_done;
		logic        tlv_end;
		logic [1:0]  error_code;
		logic        last_out;
	} result_t;

endpackage

[rtl/core/ber_tlv_stream_decoder_top.sv]
// Top level of the BER TLV stream decoder: configuration register, front and back ends.
// Depends on btlv_pkg, btlv_front and btlv_engine.
//
//  Channel   Handshake        Payload
//  input     push / full      data_byte, buffer_end
//  result    pop / empty      event_kind, tag_value, length_value, value_byte,
//                             header_done, tlv_end, error_code, last_out
//  config    cfg_we           cfg_wdata (single-byte length mode)
//
// One result is produced per input byte, and one byte is decoded per clock cycle
// in steady state while the result queue has room; the state update in the back
// end sets that rate. A byte transferred in waits in the input queue until the back
// end decodes it; its result then waits in the result queue until it is popped.
// Both queues hold CLASS_DEPTH and RESULT_DEPTH entries, so either side may stall
// without stopping the other until the queue in between fills.
// Reset clears both queues, the decoder state and the configuration register.

module ber_tlv_stream_decoder_top #(
	parameter int CLASS_DEPTH  = 4,
	parameter int RESULT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  event_kind,
	output logic [31:0] tag_value,
	output logic [31:0] length_value,
	output logic [7:0]  value_byte,
	output logic        header_done,
	output logic        tlv_end,
	output logic [1:0]  error_code,
	output logic        last_out
);

	logic                 single_byte_length_q;
	logic                 item_valid;
	logic                 item_take;
	btlv_pkg::byte_item_t item;
	btlv_pkg::result_t    result;

	// Config register: user must change mode only while no byte is in flight; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_byte_length_q <= 1'b0;
		end else if (cfg_we) begin
			single_byte_length_q <= cfg_wdata;
		end
	end

	btlv_front #(
		.DEPTH (CLASS_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.full       (full),
		.item_take  (item_take),
		.item       (item),
		.item_valid (item_valid)
	);

	btlv_engine #(
		.DEPTH (RESULT_DEPTH)
	) u_engine (
		.clk                (clk),
		.arst_n             (arst_n),
		.single_byte_length (single_byte_length_q),
		.item_valid         (item_valid),
		.item               (item),
		.item_take          (item_take),
		.pop                (pop),
		.empty              (empty),
		.result             (result)
	);

	assign event_kind   = result.event_kind;
	assign tag_value    = result.tag_value;
	assign length_value = result.length_value;
	assign value_byte   = result.value_byte;
	assign header_done  = result.header_done;
	assign tlv_end      = result.tlv_end;
	assign error_code   = result.error_code;
	assign last_out     = result.last_out;

	// A header can only be completed by a length byte.
	a_hdr_on_length: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && header_done) |-> (event_kind == btlv_pkg::KIND_LEN))
		else $error("header completed on a byte that is not a length byte");

	// Any error is reported on the last byte of the buffer and closes the TLV.
	a_err_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error_code != btlv_pkg::ERR_NONE) |-> (tlv_end && last_out))
		else $error("error reported away from the buffer end or without closing the TLV");

	// The last byte of a buffer always closes the current TLV.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_out) |-> tlv_end)
		else $error("buffer ended without closing the TLV");

endmodule

[rtl/core/btlv_fifo.sv]
// Small register-based first-in first-out queue used on both sides of the decoder.
// Depends on nothing; width and depth come from the instantiating module.

module btlv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = store_q[rd_ptr_q];

	// Entry storage; only written on an accepted transfer.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count, wrapping at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/btlv_front.sv]
// Front end of the decoder: accepts raw bytes, classifies them and queues them.
// Depends on btlv_pkg and btlv_fifo.

module btlv_front #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          data_byte,
	input  logic                buffer_end,
	output logic                full,
	input  logic                item_take,
	output btlv_pkg::byte_item_t item,
	output logic                item_valid
);

	btlv_pkg::byte_item_t class_item;
	logic                 class_empty;

	// Pre-decode the bit patterns the back end branches on.
	always_comb begin
		class_item.data     = data_byte;
		class_item.last     = buffer_end;
		class_item.bit7     = data_byte[7];
		class_item.tag_ext  = (data_byte[4:0] == btlv_pkg::TAG_EXT_MASK);
		class_item.cnt_zero = (data_byte[6:0] == 7'd0);
	end

	btlv_fifo #(
		.WIDTH ($bits(btlv_pkg::byte_item_t)),
		.DEPTH (DEPTH)
	) u_class_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (class_item),
		.full    (full),
		.rd_en   (item_take),
		.rd_data (item),
		.empty   (class_empty)
	);

	assign item_valid = !class_empty;

endmodule

[rtl/core/btlv_engine.sv]
// Back end of the decoder: runs the TLV state machine on queued bytes and queues results.
// Depends on btlv_pkg and btlv_fifo.

module btlv_engine #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 single_byte_length,
	input  logic                 item_valid,
	input  btlv_pkg::byte_item_t item,
	output logic                 item_take,
	input  logic                 pop,
	output logic                 empty,
	output btlv_pkg::result_t    result
);

	localparam logic [2:0] PH_TAG_FIRST = 3'd0;
	localparam logic [2:0] PH_TAG_MORE  = 3'd1;
	localparam logic [2:0] PH_LEN_FIRST = 3'd2;
	localparam logic [2:0] PH_LEN_MORE  = 3'd3;
	localparam logic [2:0] PH_VALUE     = 3'd4;

	logic [2:0]  phase_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [6:0]  len_left_q;
	logic [31:0] val_left_q;

	logic [2:0]  phase_n;
	logic [31:0] tag_n;
	logic [31:0] len_n;
	logic [6:0]  len_left_n;
	logic [31:0] val_left_n;

	logic        res_full;
	logic        step;
	btlv_pkg::result_t res_d;

	// A byte is processed whenever one is queued and the result queue has room.
	assign step      = item_valid && !res_full;
	assign item_take = step;

	// Next-state and result for the byte at the head of the input queue.
	always_comb begin
		phase_n          = phase_q;
		tag_n            = tag_q;
		len_n            = len_q;
		len_left_n       = len_left_q;
		val_left_n       = val_left_q;
		res_d.event_kind = btlv_pkg::KIND_TAG;
		res_d.value_byte = 8'd0;
		res_d.header_done = 1'b0;
		res_d.tlv_end    = 1'b0;
		res_d.error_code = btlv_pkg::ERR_NONE;
		res_d.last_out   = item.last;

		unique case (phase_q)
			PH_TAG_MORE: begin
				tag_n   = {tag_q[23:0], item.data};
				phase_n = item.bit7 ? PH_TAG_MORE : PH_LEN_FIRST;
			end
			PH_LEN_FIRST: begin
				res_d.event_kind = btlv_pkg::KIND_LEN;
				if (item.bit7 && !single_byte_length) begin
					len_n      = 32'd0;
					len_left_n = item.data[6:0];
					if (item.cnt_zero) begin
						res_d.header_done = 1'b1;
					end else begin
						phase_n = PH_LEN_MORE;
					end
				end else begin
					len_n             = {24'd0, item.data};
					res_d.header_done = 1'b1;
				end
			end
			PH_LEN_MORE: begin
				res_d.event_kind = btlv_pkg::KIND_LEN;
				len_n            = {len_q[23:0], item.data};
				len_left_n       = len_left_q - 7'd1;
				if (len_left_q == 7'd1) begin
					res_d.header_done = 1'b1;
				end
			end
			PH_VALUE: begin
				res_d.event_kind = btlv_pkg::KIND_VALUE;
				res_d.value_byte = item.data;
				val_left_n       = val_left_q - 32'd1;
				if (val_left_q == 32'd1) begin
					res_d.tlv_end = 1'b1;
					phase_n       = PH_TAG_FIRST;
				end
			end
			default: begin
				tag_n      = {24'd0, item.data};
				len_n      = 32'd0;
				len_left_n = 7'd0;
				val_left_n = 32'd0;
				phase_n    = item.tag_ext ? PH_TAG_MORE : PH_LEN_FIRST;
			end
		endcase

		// Header complete: either the TLV is empty or the value phase begins.
		if (res_d.header_done) begin
			if (len_n == 32'd0) begin
				res_d.tlv_end = 1'b1;
				phase_n       = PH_TAG_FIRST;
			end else begin
				val_left_n = len_n;
				phase_n    = PH_VALUE;
			end
		end

		// The buffer ended before the TLV did: report where it was cut.
		if (item.last && !res_d.tlv_end) begin
			if (phase_n == PH_TAG_MORE) begin
				res_d.error_code = btlv_pkg::ERR_TAG_SHORT;
			end else if (phase_n == PH_LEN_FIRST || phase_n == PH_LEN_MORE) begin
				res_d.error_code = btlv_pkg::ERR_LEN_SHORT;
			end else begin
				res_d.error_code = btlv_pkg::ERR_VAL_SHORT;
			end
			res_d.tlv_end = 1'b1;
			phase_n       = PH_TAG_FIRST;
			len_left_n    = 7'd0;
			val_left_n    = 32'd0;
		end

		res_d.tag_value    = tag_n;
		res_d.length_value = len_n;
	end

	// Decoder state, advanced once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG_FIRST;
			tag_q      <= 32'd0;
			len_q      <= 32'd0;
			len_left_q <= 7'd0;
			val_left_q <= 32'd0;
		end else if (step) begin
			phase_q    <= phase_n;
			tag_q      <= tag_n;
			len_q      <= len_n;
			len_left_q <= len_left_n;
			val_left_q <= val_left_n;
		end
	end

	btlv_fifo #(
		.WIDTH ($bits(btlv_pkg::result_t)),
		.DEPTH (DEPTH)
	) u_result_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (step),
		.wr_data (res_d),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

[tb/ber_tlv_stream_decoder_top_tb.sv]
// Self-checking testbench for the BER TLV stream decoder: a directed table, then random buffers.
// Depends on btlv_pkg and ber_tlv_stream_decoder_top; predicts each result with its own decoder.
`timescale 1ns / 1ps

module ber_tlv_stream_decoder_top_tb;

	typedef enum logic [2:0] {
		P_TAG_FIRST,
		P_TAG_MORE,
		P_LEN_FIRST,
		P_LEN_MORE,
		P_VALUE
	} dec_phase_t;

	typedef struct {
		logic [7:0]        data;
		logic              eob;
		bit                known;
		btlv_pkg::result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        buffer_end = 1'b0;
	logic        pop = 1'b0;
	logic        empty;
	logic [1:0]  event_kind;
	logic [31:0] tag_value;
	logic [31:0] length_value;
	logic [7:0]  value_byte;
	logic        header_done;
	logic        tlv_end;
	logic [1:0]  error_code;
	logic        last_out;

	// Decoder state of the predictor and its copy of the mode register.
	dec_phase_t  dec_phase = P_TAG_FIRST;
	logic [31:0] tag_acc = '0;
	logic [31:0] len_acc = '0;
	logic [6:0]  len_left = '0;
	logic [31:0] val_left = '0;
	logic        sbl_mode = 1'b0;

	btlv_pkg::result_t decoded_q[$];
	logic [7:0]        buf_bytes[$];
	stim_row_t         dir_rows[26];
	int unsigned       bytes_sent = 0;
	int unsigned       err_count = 0;
	bit                steady = 1'b0;

	ber_tlv_stream_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.buffer_end(buffer_end),
		.pop(pop),
		.empty(empty),
		.event_kind(event_kind),
		.tag_value(tag_value),
		.length_value(length_value),
		.value_byte(value_byte),
		.header_done(header_done),
		.tlv_end(tlv_end),
		.error_code(error_code),
		.last_out(last_out)
	);

	always #6 clk = ~clk;

	// Advances the predictor by one byte and returns the result that byte must give.
	function automatic btlv_pkg::result_t decode_byte(input logic [7:0] b, input logic eob);
		btlv_pkg::result_t r;
		logic              hdr;
		r = '0;
		hdr = 1'b0;
		case (dec_phase)
			P_TAG_MORE: begin
				r.event_kind = btlv_pkg::KIND_TAG;
				tag_acc = {tag_acc[23:0], b};
				dec_phase = b[7] ? P_TAG_MORE : P_LEN_FIRST;
			end
			P_LEN_FIRST: begin
				r.event_kind = btlv_pkg::KIND_LEN;
				if (b[7] && !sbl_mode) begin
					len_acc = '0;
					len_left = b[6:0];
					if (b[6:0] == 7'd0)
						hdr = 1'b1;
					else
						dec_phase = P_LEN_MORE;
				end else begin
					len_acc = {24'd0, b};
					hdr = 1'b1;
				end
			end
			P_LEN_MORE: begin
				r.event_kind = btlv_pkg::KIND_LEN;
				len_acc = {len_acc[23:0], b};
				len_left = len_left - 7'd1;
				if (len_left == 7'd0)
					hdr = 1'b1;
			end
			P_VALUE: begin
				r.event_kind = btlv_pkg::KIND_VALUE;
				r.value_byte = b;
				val_left = val_left - 32'd1;
				if (val_left == 32'd0) begin
					r.tlv_end = 1'b1;
					dec_phase = P_TAG_FIRST;
				end
			end
			default: begin
				r.event_kind = btlv_pkg::KIND_TAG;
				tag_acc = {24'd0, b};
				len_acc = '0;
				len_left = '0;
				val_left = '0;
				dec_phase = (b[4:0] == btlv_pkg::TAG_EXT_MASK) ? P_TAG_MORE : P_LEN_FIRST;
			end
		endcase

		// A finished header either closes an empty TLV or opens the value.
		if (hdr) begin
			if (len_acc == 32'd0) begin
				r.tlv_end = 1'b1;
				dec_phase = P_TAG_FIRST;
			end else begin
				val_left = len_acc;
				dec_phase = P_VALUE;
			end
		end

		// The buffer ending inside a TLV closes it with an error.
		if (eob && !r.tlv_end) begin
			if (dec_phase == P_TAG_MORE)
				r.error_code = btlv_pkg::ERR_TAG_SHORT;
			else if (dec_phase == P_LEN_FIRST || dec_phase == P_LEN_MORE)
				r.error_code = btlv_pkg::ERR_LEN_SHORT;
			else
				r.error_code = btlv_pkg::ERR_VAL_SHORT;
			r.tlv_end = 1'b1;
			dec_phase = P_TAG_FIRST;
			len_left = '0;
			val_left = '0;
		end

		r.tag_value = tag_acc;
		r.length_value = len_acc;
		r.header_done = hdr;
		r.last_out = eob;
		return r;
	endfunction

	function automatic stim_row_t row_plain(input logic [7:0] d, input logic eob);
		stim_row_t s;
		s.data = d;
		s.eob = eob;
		s.known = 1'b0;
		s.res = '0;
		return s;
	endfunction

	function automatic stim_row_t row_known(input logic [7:0] d, input logic eob,
			input logic [1:0] kind, input logic [31:0] tag, input logic [31:0] len,
			input logic hdr, input logic done, input logic [1:0] err);
		stim_row_t s;
		s.data = d;
		s.eob = eob;
		s.known = 1'b1;
		s.res = '{event_kind: kind, tag_value: tag, length_value: len, value_byte: 8'h00,
			header_done: hdr, tlv_end: done, error_code: err, last_out: eob};
		return s;
	endfunction

	// Appends one TLV to the pending buffer. Returns 1 when its value is cut off,
	// in which case the buffer has to end straight after it.
	function automatic bit add_tlv();
		logic [7:0]  b;
		logic [31:0] len;
		int unsigned need;
		int unsigned n_len;
		int unsigned n_val;
		bit          cut;
		b = 8'($urandom);
		if ($urandom_range(2) == 0)
			b[4:0] = btlv_pkg::TAG_EXT_MASK;
		buf_bytes.push_back(b);
		if (b[4:0] == btlv_pkg::TAG_EXT_MASK) begin
			repeat ($urandom_range(5)) buf_bytes.push_back(8'($urandom) | 8'h80);
			buf_bytes.push_back(8'($urandom) & 8'h7F);
		end

		// Mostly short values; now and then a long one whose buffer stops early.
		cut = ($urandom_range(9) == 0);
		if (cut)
			len = sbl_mode ? 32'($urandom_range(255, 7)) : (32'($urandom) | 32'd7);
		else if ($urandom_range(3) == 0)
			len = 32'($urandom_range(24));
		else
			len = 32'($urandom_range(6));

		if (sbl_mode || (len < 32'd128 && $urandom_range(1) == 0)) begin
			buf_bytes.push_back(len[7:0]);
		end else begin
			// Long form, sometimes padded beyond four bytes with leading garbage.
			need = 0;
			while (need < 4 && (len >> (8 * need)) != 0)
				need++;
			n_len = $urandom_range(6, need);
			buf_bytes.push_back(8'h80 | 8'(n_len));
			for (int k = int'(n_len) - 1; k >= 0; k--) begin
				if (k < 4)
					b = len[8 * k +: 8];
				else
					b = $urandom_range(1) ? 8'($urandom) : 8'h00;
				buf_bytes.push_back(b);
			end
		end

		n_val = cut ? $urandom_range(6) : len;
		repeat (n_val) buf_bytes.push_back(8'($urandom));
		return cut;
	endfunction

	// Offers one byte, with a random hold-off unless steady is set, until its transfer takes place.
	task automatic send_byte(input logic [7:0] b, input logic eob,
			input btlv_pkg::result_t want);
		while (!steady && $urandom_range(99) < 19) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		buffer_end <= eob;
		do
			@(posedge clk);
		while (full);
		decoded_q.push_back(want);
		bytes_sent++;
	endtask

	// Sends whole buffers until at least count further bytes have gone in.
	task automatic send_random(input int unsigned count);
		int unsigned target;
		int unsigned n;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			buf_bytes.delete();
			if ($urandom_range(19) == 0) begin
				repeat ($urandom_range(8, 1)) buf_bytes.push_back(8'($urandom));
			end else begin
				for (int t = $urandom_range(4, 1); t > 0; t--)
					if (add_tlv())
						break;
				// Now and then the buffer stops at an arbitrary byte.
				if ($urandom_range(9) == 0) begin
					n = $urandom_range(buf_bytes.size(), 1);
					while (buf_bytes.size() > n)
						void'(buf_bytes.pop_back());
				end
			end
			foreach (buf_bytes[i])
				send_byte(buf_bytes[i], i == buf_bytes.size() - 1,
					decode_byte(buf_bytes[i], i == buf_bytes.size() - 1));
		end
	endtask

	// Writes the mode register once every outstanding result has come back.
	task automatic set_mode(input logic m);
		push <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sbl_mode = m;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// Result side: check each transfer against the oldest prediction; stall at random unless steady.
	always @(posedge clk) begin
		btlv_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (decoded_q.size() == 0) begin
				$error("result transfer with no byte outstanding");
				err_count++;
			end else begin
				want = decoded_q.pop_front();
				check_field("event_kind", 32'(want.event_kind), 32'(event_kind));
				check_field("tag_value", want.tag_value, tag_value);
				check_field("length_value", want.length_value, length_value);
				check_field("value_byte", 32'(want.value_byte), 32'(value_byte));
				check_field("header_done", 32'(want.header_done), 32'(header_done));
				check_field("tlv_end", 32'(want.tlv_end), 32'(tlv_end));
				check_field("error_code", 32'(want.error_code), 32'(error_code));
				check_field("last_out", 32'(want.last_out), 32'(last_out));
			end
		end
		pop <= arst_n && (steady || $urandom_range(99) >= 19);
	end

	// Main sequence: reset, directed table, then random buffers under both modes.
	initial begin
		btlv_pkg::result_t r;
		dir_rows = '{
			row_known(8'h00, 1'b0, btlv_pkg::KIND_TAG, 32'h0, 32'h0,
				1'b0, 1'b0, btlv_pkg::ERR_NONE),
			row_known(8'h00, 1'b0, btlv_pkg::KIND_LEN, 32'h0, 32'h0,
				1'b1, 1'b1, btlv_pkg::ERR_NONE),
			row_known(8'hFF, 1'b0, btlv_pkg::KIND_TAG, 32'hFF, 32'h0,
				1'b0, 1'b0, btlv_pkg::ERR_NONE),
			row_plain(8'hFF, 1'b0),
			row_plain(8'h81, 1'b0),
			row_plain(8'h80, 1'b0),
			row_plain(8'h01, 1'b0),
			row_plain(8'h85, 1'b0),
			row_plain(8'hFF, 1'b0),
			row_plain(8'h00, 1'b0),
			row_plain(8'h00, 1'b0),
			row_plain(8'h00, 1'b0),
			row_plain(8'h02, 1'b0),
			row_plain(8'hAB, 1'b0),
			row_plain(8'h55, 1'b0),
			row_known(8'h1F, 1'b1, btlv_pkg::KIND_TAG, 32'h1F, 32'h0,
				1'b0, 1'b1, btlv_pkg::ERR_TAG_SHORT),
			row_plain(8'h04, 1'b0),
			row_plain(8'h80, 1'b0),
			row_known(8'h30, 1'b1, btlv_pkg::KIND_TAG, 32'h30, 32'h0,
				1'b0, 1'b1, btlv_pkg::ERR_LEN_SHORT),
			row_plain(8'h04, 1'b0),
			row_known(8'h7F, 1'b1, btlv_pkg::KIND_LEN, 32'h04, 32'h7F,
				1'b1, 1'b1, btlv_pkg::ERR_VAL_SHORT),
			row_plain(8'h04, 1'b0),
			row_plain(8'h02, 1'b0),
			row_plain(8'h11, 1'b1),
			row_plain(8'h05, 1'b0),
			row_plain(8'h00, 1'b1)
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(1'b0);
		foreach (dir_rows[i]) begin
			r = decode_byte(dir_rows[i].data, dir_rows[i].eob);
			if (dir_rows[i].known)
				r = dir_rows[i].res;
			send_byte(dir_rows[i].data, dir_rows[i].eob, r);
		end

		set_mode(1'b1);
		send_random(450);
		set_mode(1'b0);
		steady = 1'b1;
		send_random(200);
		steady = 1'b0;
		send_random(250);
		set_mode(1'b1);
		send_random(450);

		// Drain: every prediction must be matched before the verdict.
		push <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("PASS ber_tlv_stream_decoder_top");
		else
			$display("FAIL ber_tlv_stream_decoder_top");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("FAIL ber_tlv_stream_decoder_top");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/btlv_pkg.sv
rtl/core/btlv_fifo.sv
rtl/core/btlv_front.sv
rtl/core/btlv_engine.sv
rtl/core/ber_tlv_stream_decoder_top.sv
tb/ber_tlv_stream_decoder_top_tb.sv
